### design/cdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the console divider timer
// Holds the event codes, the register offsets, the period table and the
// structures that pass between the timer modules.
// ----------------------------------------------------------------------------
package cdt_pkg;

	localparam int CYCLES_MAX = 255;
	localparam int MIN_PERIOD = 16;
	localparam int CYC_W      = 8;
	localparam int PHASE_W    = 11;
	localparam int TICK_W     = $clog2((255 - 1) / MIN_PERIOD + 2);

	localparam logic [1:0] MODE_ADVANCE = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_TIMA = 2'd1;
	localparam logic [1:0] REG_TMA  = 2'd2;
	localparam logic [1:0] REG_TAC  = 2'd3;

	localparam logic [PHASE_W-1:0] PHASE_RESET = 11'd1024;

	typedef struct packed {
		logic [TICK_W-1:0]  ticks;
		logic [PHASE_W-1:0] phase;
	} presc_res_t;

	typedef struct packed {
		logic       timer_irq;
		logic [7:0] read_data;
	} result_t;

	function automatic logic [PHASE_W-1:0] period(input logic [1:0] rate);
		logic [PHASE_W-1:0] p;
		unique case (rate)
			2'd0: p = 11'd1024;
			2'd1: p = 11'd16;
			2'd2: p = 11'd64;
			2'd3: p = 11'd256;
			default: p = 11'd1024;
		endcase
		return p;
	endfunction

	function automatic logic [3:0] period_shift(input logic [1:0] rate);
		logic [3:0] s;
		unique case (rate)
			2'd0: s = 4'd10;
			2'd1: s = 4'd4;
			2'd2: s = 4'd6;
			2'd3: s = 4'd8;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

endpackage

### design/cdt_prescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_prescale: tick derivation for one advance
// Splits the elapsed cycles into whole periods and the remainder, takes the
// remainder from the prescaler phase and returns the tick count and new phase.
// ----------------------------------------------------------------------------
module cdt_prescale (
	input  logic [cdt_pkg::CYC_W-1:0]   cyc,
	input  logic [1:0]                  rate_select,
	input  logic [cdt_pkg::PHASE_W-1:0] phase,
	output cdt_pkg::presc_res_t         res
);

	logic [cdt_pkg::PHASE_W-1:0] p;
	logic [3:0]                  sh;
	logic [cdt_pkg::PHASE_W-1:0] cyc_w;
	logic [cdt_pkg::PHASE_W-1:0] cyc_m1;
	logic [cdt_pkg::PHASE_W-1:0] cyc_r;
	logic [cdt_pkg::PHASE_W-1:0] n_w;
	logic [cdt_pkg::PHASE_W:0]   sum;

	always_comb begin
		p      = cdt_pkg::period(rate_select);
		sh     = cdt_pkg::period_shift(rate_select);
		cyc_w  = {{(cdt_pkg::PHASE_W - cdt_pkg::CYC_W){1'b0}}, cyc};
		cyc_m1 = cyc_w - 11'd1;
		sum    = '0;
		if (cyc_w > p) begin
			n_w   = cyc_m1 >> sh;
			cyc_r = (cyc_m1 & (p - 11'd1)) + 11'd1;
		end else begin
			n_w   = '0;
			cyc_r = cyc_w;
		end
		if (phase <= cyc_r) begin
			sum       = {1'b0, phase} + {1'b0, p} - {1'b0, cyc_r};
			res.phase = sum[cdt_pkg::PHASE_W-1:0];
			res.ticks = n_w[cdt_pkg::TICK_W-1:0] + 5'd1;
		end else begin
			res.phase = phase - cyc_r;
			res.ticks = n_w[cdt_pkg::TICK_W-1:0];
		end
	end

endmodule

### design/cdt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_core: timer registers and tick sequencer
// Holds the divider, counter, reload, control and phase registers, executes
// writes and reads at once and applies the ticks of an advance one per cycle
// through a single counter incrementer.
// ----------------------------------------------------------------------------
module cdt_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic [1:0]                reg_offset,
	input  logic [7:0]                write_byte,
	input  logic [cdt_pkg::CYC_W-1:0] cycle_count,
	output logic                      res_valid,
	input  logic                      res_ready,
	output cdt_pkg::result_t          res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0]                  state_q;
	logic [15:0]                 divider_q;
	logic [7:0]                  counter_q;
	logic [7:0]                  reload_q;
	logic                        enable_q;
	logic [1:0]                  rate_q;
	logic [cdt_pkg::PHASE_W-1:0] phase_q;
	logic [cdt_pkg::TICK_W-1:0]  ticks_q;
	logic                        irq_q;
	logic [7:0]                  rd_q;

	logic [cdt_pkg::CYC_W-1:0]   cyc_sat;
	cdt_pkg::presc_res_t         presc;
	logic                        accept;
	logic [7:0]                  rd_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == ST_DONE);
	assign res.read_data = rd_q;
	assign res.timer_irq = irq_q;

	assign cyc_sat = ({8'd0, cycle_count} > 16'(cdt_pkg::CYCLES_MAX)) ?
		cdt_pkg::CYC_W'(cdt_pkg::CYCLES_MAX) : cycle_count;

	cdt_prescale u_prescale (
		.cyc         (cyc_sat),
		.rate_select (rate_q),
		.phase       (phase_q),
		.res         (presc)
	);

	always_comb begin
		unique case (reg_offset)
			cdt_pkg::REG_DIV:  rd_next = divider_q[15:8];
			cdt_pkg::REG_TIMA: rd_next = counter_q;
			cdt_pkg::REG_TMA:  rd_next = reload_q;
			cdt_pkg::REG_TAC:  rd_next = {5'd0, enable_q, rate_q};
			default:           rd_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			divider_q <= '0;
			counter_q <= '0;
			reload_q  <= '0;
			enable_q  <= 1'b0;
			rate_q    <= '0;
			phase_q   <= cdt_pkg::PHASE_RESET;
			ticks_q   <= '0;
			irq_q     <= 1'b0;
			rd_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						irq_q   <= 1'b0;
						rd_q    <= '0;
						ticks_q <= '0;
						state_q <= ST_DONE;
						unique case (mode)
							cdt_pkg::MODE_ADVANCE: begin
								divider_q <= divider_q + {8'd0, cyc_sat};
								if (enable_q) begin
									phase_q <= presc.phase;
									ticks_q <= presc.ticks;
									if (presc.ticks != '0) begin
										state_q <= ST_COUNT;
									end
								end
							end
							cdt_pkg::MODE_WRITE: begin
								unique case (reg_offset)
									cdt_pkg::REG_DIV:  divider_q <= '0;
									cdt_pkg::REG_TIMA: counter_q <= write_byte;
									cdt_pkg::REG_TMA:  reload_q  <= write_byte;
									cdt_pkg::REG_TAC: begin
										enable_q <= write_byte[2];
										rate_q   <= write_byte[1:0];
										phase_q  <= cdt_pkg::period(write_byte[1:0]);
									end
									default: divider_q <= divider_q;
								endcase
							end
							cdt_pkg::MODE_READ: rd_q <= rd_next;
							cdt_pkg::MODE_NONE: rd_q <= '0;
							default:            rd_q <= '0;
						endcase
					end
				end
				ST_COUNT: begin
					if (counter_q == 8'hFF) begin
						counter_q <= reload_q;
						irq_q     <= 1'b1;
					end else begin
						counter_q <= counter_q + 8'd1;
					end
					ticks_q <= ticks_q - 5'd1;
					if (ticks_q == 5'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/console_divider_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_divider_timer: emulated console divider and timer
// Order: a write, read or unused event goes from the idle state to the done
// state and then into the m_tvalid register; an advance with k ticks (k is at
// most 16) first passes the count state, where the counter incrementer applies
// one tick per cycle. A new transaction is taken only in the idle state.
// Reset: arst_n clears core registers and m_tvalid, prescaler phase is 1024.
// ----------------------------------------------------------------------------
module console_divider_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // mode, reg_offset, write_byte, cycle_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data, timer_irq
);

	logic             res_valid;
	logic             res_ready;
	cdt_pkg::result_t res;
	logic             m_valid_q;
	cdt_pkg::result_t m_data_q;

	assign res_ready = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {7'd0, m_data_q.timer_irq, m_data_q.read_data};

	cdt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.mode        (s_tdata[1:0]),
		.reg_offset  (s_tdata[3:2]),
		.write_byte  (s_tdata[11:4]),
		.cycle_count (s_tdata[19:12]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= res;
		end
	end

endmodule

### design/cdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_checker: port checks of the console divider timer
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
module cdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output transaction dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Output data changed while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted while an event is still in progress.");

	a_irq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:9] == 7'd0) && !(m_tdata[8] && (m_tdata[7:0] != 8'd0)))
		else $error("Interrupt flag and read data reported together.");

endmodule

bind console_divider_timer cdt_checker u_cdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### sim/tb_console_divider_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_divider_timer: self-checking testbench of the console timer
// A directed table covers the register extremes, every event kind, the divider
// clear, the control bit masking and the unused mode. Random events follow
// under four idling patterns. Each result is checked against the table's fixed
// value or a behavioral copy of the divider, counter, reload and prescaler state.
// ----------------------------------------------------------------------------
module tb_console_divider_timer;

	localparam int N_DIRECTED   = 25;
	localparam int N_PER_PHASE  = 125;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] offset;
		logic [7:0] data;
		logic [7:0] cycles;
		logic       fixed;
		logic [7:0] rd;
		logic       irq;
	} dir_row_t;

	localparam int unsigned PERIOD_OF [4] = '{1024, 16, 64, 256};

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_DIV,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TIMA, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TMA,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TAC,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_DIV,  8'h00, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_DIV,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_DIV,  8'h00, 8'h00, 1'b1, 8'h01, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_DIV,  8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_DIV,  8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_TMA,  8'hFF, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_TIMA, 8'hFE, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_TAC,  8'hFD, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TAC,  8'h00, 8'h00, 1'b1, 8'h05, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_DIV,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TIMA, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_DIV,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_DIV,  8'h00, 8'h01, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_TAC,  8'h07, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_TAC,  8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_TAC,  8'h04, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_ADVANCE, cdt_pkg::REG_DIV,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0},
		'{cdt_pkg::MODE_NONE,    cdt_pkg::REG_TAC,  8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_WRITE,   cdt_pkg::REG_TAC,  8'hFA, 8'h00, 1'b1, 8'h00, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TAC,  8'hFF, 8'hFF, 1'b1, 8'h02, 1'b0},
		'{cdt_pkg::MODE_READ,    cdt_pkg::REG_TMA,  8'h00, 8'h00, 1'b1, 8'hFF, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // mode, reg_offset, write_byte, cycle_count
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // read_data, timer_irq

	logic [15:0] tmr_div;
	logic [7:0]  tmr_cnt;
	logic [7:0]  tmr_reload;
	logic        tmr_en;
	logic [1:0]  tmr_rate;
	logic [10:0] tmr_phase;

	cdt_pkg::result_t pending_results [$];
	int               mismatches;
	int               src_idle_pct;
	int               snk_stall_pct;

	console_divider_timer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic cdt_pkg::result_t timer_event(input logic [1:0] mode,
			input logic [1:0] offset, input logic [7:0] data, input logic [7:0] cycles);
		cdt_pkg::result_t r;
		int unsigned      p;
		int unsigned      c;
		int unsigned      n;
		int unsigned      ph;
		int unsigned      ticks;
		r     = '0;
		p     = PERIOD_OF[tmr_rate];
		c     = cycles;
		ticks = 0;
		case (mode)
			cdt_pkg::MODE_ADVANCE: begin
				if (c > cdt_pkg::CYCLES_MAX)
					c = cdt_pkg::CYCLES_MAX;
				tmr_div = tmr_div + 16'(c);
				if (tmr_en) begin
					if (c > p) begin
						n     = (c - 1) / p;
						ticks = n;
						c     = c - n * p;
					end
					ph = tmr_phase;
					if (ph <= c) begin
						ph    = ph + p - c;
						ticks = ticks + 1;
					end else begin
						ph = ph - c;
					end
					tmr_phase = 11'(ph);
					repeat (ticks) begin
						tmr_cnt = tmr_cnt + 8'd1;
						if (tmr_cnt == 8'd0) begin
							r.timer_irq = 1'b1;
							tmr_cnt     = tmr_reload;
						end
					end
				end
			end
			cdt_pkg::MODE_WRITE: begin
				case (offset)
					cdt_pkg::REG_DIV:  tmr_div = '0;
					cdt_pkg::REG_TIMA: tmr_cnt = data;
					cdt_pkg::REG_TMA:  tmr_reload = data;
					default: begin
						tmr_en    = data[2];
						tmr_rate  = data[1:0];
						tmr_phase = 11'(PERIOD_OF[data[1:0]]);
					end
				endcase
			end
			cdt_pkg::MODE_READ: begin
				case (offset)
					cdt_pkg::REG_DIV:  r.read_data = tmr_div[15:8];
					cdt_pkg::REG_TIMA: r.read_data = tmr_cnt;
					cdt_pkg::REG_TMA:  r.read_data = tmr_reload;
					default:           r.read_data = {5'd0, tmr_en, tmr_rate};
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_event(input logic [1:0] mode, input logic [1:0] offset,
			input logic [7:0] data, input logic [7:0] cycles, input logic fixed,
			input cdt_pkg::result_t fixed_res);
		cdt_pkg::result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, cycles, data, offset, mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = timer_event(mode, offset, data, cycles);
		if (fixed)
			pending_results.push_back(fixed_res);
		else
			pending_results.push_back(r);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		m_tready <= arst_n ? ($urandom_range(99) >= snk_stall_pct) : 1'b0;
	end

	always @(posedge clk) begin
		cdt_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.read_data)
					report_mismatch("read_data", m_tdata[7:0], want.read_data);
				if (m_tdata[8] !== want.timer_irq)
					report_mismatch("timer_irq", m_tdata[8], want.timer_irq);
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [1:0]       mode;
		logic [1:0]       offset;
		logic [7:0]       data;
		logic [7:0]       cycles;
		int               pick;
		cdt_pkg::result_t typed;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		mismatches    = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		tmr_div       = '0;
		tmr_cnt       = '0;
		tmr_reload    = '0;
		tmr_en        = 1'b0;
		tmr_rate      = '0;
		tmr_phase     = cdt_pkg::PHASE_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			typed.read_data = DIRECTED[i].rd;
			typed.timer_irq = DIRECTED[i].irq;
			send_event(DIRECTED[i].mode, DIRECTED[i].offset, DIRECTED[i].data,
				DIRECTED[i].cycles, DIRECTED[i].fixed, typed);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
				default: begin src_idle_pct = 22; snk_stall_pct = 22; end
			endcase
			for (int i = 0; i < N_PER_PHASE; i++) begin
				pick   = $urandom_range(99);
				offset = 2'($urandom_range(3));
				data   = 8'($urandom);
				if ($urandom_range(2) == 0)
					cycles = 8'($urandom_range(20));
				else
					cycles = 8'($urandom_range(255));
				if (pick < 50)
					mode = cdt_pkg::MODE_ADVANCE;
				else if (pick < 70)
					mode = cdt_pkg::MODE_WRITE;
				else if (pick < 90)
					mode = cdt_pkg::MODE_READ;
				else
					mode = cdt_pkg::MODE_NONE;
				// Keep the timer running most of the time so that the counter wraps.
				if (mode == cdt_pkg::MODE_WRITE && offset == cdt_pkg::REG_TAC &&
						$urandom_range(4) != 0)
					data[2] = 1'b1;
				send_event(mode, offset, data, cycles, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
